// ----- hw/rtl/ctp_pkg.sv -----
package ctp_pkg;

   localparam int COORD_W  = 16;
   localparam int RADIUS_W = 15;
   localparam int WIDTH_W  = 14;
   localparam int LINE_W   = 32;
   localparam int DIFF_W   = 17;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 14'd640;

   localparam int COORD_MAX = 32767;
   localparam int COORD_MIN_MAG = 32768;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [LINE_W-1:0]  line_type;

   typedef struct packed {
      logic     vertical;
      line_type left_y;
      line_type right_y;
   } line_res_type;

endpackage

// ----- hw/rtl/ctp_div.sv -----
module ctp_div #(
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [CMP_W-1:0]  rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [QUO_W-1:0]  valid_ff;

   logic [CMP_W-1:0]  rem_cur  [QUO_W];
   logic [DEN_W-1:0]  den_cur  [QUO_W];
   logic [QUO_W-1:0]  quo_cur  [QUO_W];
   logic [SIDE_W-1:0] side_cur [QUO_W];
   logic [QUO_W-1:0]  valid_cur;

   logic [CMP_W-1:0]  rem_in [QUO_W];
   logic [QUO_W-1:0]  quo_in [QUO_W];

   // one quotient bit per stage, most significant first
   always_comb begin
      logic [CMP_W-1:0] trial;
      rem_cur[0]   = CMP_W'(num);
      den_cur[0]   = den;
      quo_cur[0]   = '0;
      side_cur[0]  = in_side;
      valid_cur[0] = in_valid;
      for (int s = 1; s < QUO_W; s++) begin
         rem_cur[s]   = rem_ff[s-1];
         den_cur[s]   = den_ff[s-1];
         quo_cur[s]   = quo_ff[s-1];
         side_cur[s]  = side_ff[s-1];
         valid_cur[s] = valid_ff[s-1];
      end
      for (int s = 0; s < QUO_W; s++) begin
         trial     = CMP_W'(den_cur[s]) << (QUO_W - 1 - s);
         rem_in[s] = rem_cur[s];
         quo_in[s] = quo_cur[s];
         if (rem_cur[s] >= trial) begin
            rem_in[s] = rem_cur[s] - trial;
            quo_in[s][QUO_W-1-s] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QUO_W; s++) begin
         rem_ff[s]  <= rem_in[s];
         den_ff[s]  <= den_cur[s];
         quo_ff[s]  <= quo_in[s];
         side_ff[s] <= side_cur[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_cur;
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// ----- hw/rtl/ctp_sqrt.sv -----
module ctp_sqrt #(
   parameter int RAD_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   radicand,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [RAD_W/2-1:0] root,
   output logic [SIDE_W-1:0]  out_side
);

   localparam int RT_W  = RAD_W / 2;
   localparam int REM_W = RT_W + 3;

   logic [REM_W-1:0]  rem_ff  [RT_W];
   logic [RAD_W-1:0]  rad_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];
   logic [RT_W-1:0]   valid_ff;

   logic [REM_W-1:0]  rem_cur  [RT_W];
   logic [RAD_W-1:0]  rad_cur  [RT_W];
   logic [RT_W-1:0]   root_cur [RT_W];
   logic [SIDE_W-1:0] side_cur [RT_W];
   logic [RT_W-1:0]   valid_cur;

   logic [REM_W-1:0]  rem_in  [RT_W];
   logic [RAD_W-1:0]  rad_in  [RT_W];
   logic [RT_W-1:0]   root_in [RT_W];

   // one root bit per stage, two radicand bits brought down each time
   always_comb begin
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      rem_cur[0]   = '0;
      rad_cur[0]   = radicand;
      root_cur[0]  = '0;
      side_cur[0]  = in_side;
      valid_cur[0] = in_valid;
      for (int s = 1; s < RT_W; s++) begin
         rem_cur[s]   = rem_ff[s-1];
         rad_cur[s]   = rad_ff[s-1];
         root_cur[s]  = root_ff[s-1];
         side_cur[s]  = side_ff[s-1];
         valid_cur[s] = valid_ff[s-1];
      end
      for (int s = 0; s < RT_W; s++) begin
         rem_t     = {rem_cur[s][REM_W-3:0], rad_cur[s][RAD_W-1 -: 2]};
         trial     = {1'b0, root_cur[s], 2'b01};
         rad_in[s] = rad_cur[s] << 2;
         if (rem_t >= trial) begin
            rem_in[s]  = rem_t - trial;
            root_in[s] = {root_cur[s][RT_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = rem_t;
            root_in[s] = {root_cur[s][RT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < RT_W; s++) begin
         rem_ff[s]  <= rem_in[s];
         rad_ff[s]  <= rad_in[s];
         root_ff[s] <= root_in[s];
         side_ff[s] <= side_cur[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_cur;
      end
   end

   assign out_valid = valid_ff[RT_W-1];
   assign root      = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

// ----- hw/rtl/ctp_line.sv -----
module ctp_line #(
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ctp_pkg::coord_type    point_x,
   input  ctp_pkg::coord_type    point_y,
   input  ctp_pkg::coord_type    tan_x,
   input  ctp_pkg::coord_type    tan_y,
   input  ctp_pkg::diff_type     clip_left,
   input  ctp_pkg::diff_type     clip_right,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output ctp_pkg::line_res_type result,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int DW     = ctp_pkg::DIFF_W;
   localparam int PROD_W = 2 * DW;
   localparam int NUM_W  = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int LW     = ctp_pkg::LINE_W;

   // stage A: differences
   logic                  va_ff;
   ctp_pkg::diff_type     den_a_ff, rise_a_ff, run_l_a_ff, run_r_a_ff;
   ctp_pkg::coord_type    py_a_ff;
   logic                  vert_a_ff;
   logic [SIDE_W-1:0]     side_a_ff;

   always_ff @(posedge clock) begin
      den_a_ff   <= DW'(tan_x) - DW'(point_x);
      rise_a_ff  <= DW'(tan_y) - DW'(point_y);
      run_l_a_ff <= clip_left - DW'(point_x);
      run_r_a_ff <= clip_right - DW'(point_x);
      py_a_ff    <= point_y;
      vert_a_ff  <= (tan_x == point_x);
      side_a_ff  <= in_side;
   end

   // stage B: products
   logic                     vb_ff;
   logic signed [PROD_W-1:0] base_b_ff, pl_b_ff, pr_b_ff;
   logic                     den_neg_b_ff;
   logic [DW-1:0]            den_mag_b_ff;
   logic                     vert_b_ff;
   logic [SIDE_W-1:0]        side_b_ff;

   always_ff @(posedge clock) begin
      base_b_ff    <= PROD_W'(py_a_ff) * PROD_W'(den_a_ff);
      pl_b_ff      <= PROD_W'(rise_a_ff) * PROD_W'(run_l_a_ff);
      pr_b_ff      <= PROD_W'(rise_a_ff) * PROD_W'(run_r_a_ff);
      den_neg_b_ff <= den_a_ff[DW-1];
      den_mag_b_ff <= den_a_ff[DW-1] ? DW'(-den_a_ff) : DW'(den_a_ff);
      vert_b_ff    <= vert_a_ff;
      side_b_ff    <= side_a_ff;
   end

   // stage C1: numerators
   logic                    vc1_ff;
   logic signed [NUM_W-1:0] nl_c1_ff, nr_c1_ff;
   logic                    den_neg_c1_ff;
   logic [DW-1:0]           den_mag_c1_ff;
   logic                    vert_c1_ff;
   logic [SIDE_W-1:0]       side_c1_ff;

   always_ff @(posedge clock) begin
      nl_c1_ff      <= NUM_W'(base_b_ff) + NUM_W'(pl_b_ff);
      nr_c1_ff      <= NUM_W'(base_b_ff) + NUM_W'(pr_b_ff);
      den_neg_c1_ff <= den_neg_b_ff;
      den_mag_c1_ff <= den_mag_b_ff;
      vert_c1_ff    <= vert_b_ff;
      side_c1_ff    <= side_b_ff;
   end

   // stage C2: sign and magnitude
   logic              vc2_ff;
   logic              neg_l_c2_ff, neg_r_c2_ff;
   logic [MAG_W-1:0]  mag_l_c2_ff, mag_r_c2_ff;
   logic [DW-1:0]     den_mag_c2_ff;
   logic              vert_c2_ff;
   logic [SIDE_W-1:0] side_c2_ff;

   always_ff @(posedge clock) begin
      neg_l_c2_ff   <= nl_c1_ff[NUM_W-1] ^ den_neg_c1_ff;
      neg_r_c2_ff   <= nr_c1_ff[NUM_W-1] ^ den_neg_c1_ff;
      mag_l_c2_ff   <= nl_c1_ff[NUM_W-1] ? MAG_W'(-nl_c1_ff) : MAG_W'(nl_c1_ff);
      mag_r_c2_ff   <= nr_c1_ff[NUM_W-1] ? MAG_W'(-nr_c1_ff) : MAG_W'(nr_c1_ff);
      den_mag_c2_ff <= den_mag_c1_ff;
      vert_c2_ff    <= vert_c1_ff;
      side_c2_ff    <= side_c1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         vc1_ff <= 1'b0;
         vc2_ff <= 1'b0;
      end else begin
         va_ff  <= in_valid;
         vb_ff  <= va_ff;
         vc1_ff <= vb_ff;
         vc2_ff <= vc1_ff;
      end
   end

   logic              dl_valid, dr_valid;
   logic [MAG_W-1:0]  quo_l, quo_r;
   logic [SIDE_W+1:0] dl_side;
   logic              dr_neg;

   ctp_div #(
      .NUM_W  (MAG_W),
      .DEN_W  (DW),
      .QUO_W  (MAG_W),
      .SIDE_W (SIDE_W + 2)
   ) u_div_left (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc2_ff),
      .num       (mag_l_c2_ff),
      .den       (den_mag_c2_ff),
      .in_side   ({neg_l_c2_ff, vert_c2_ff, side_c2_ff}),
      .out_valid (dl_valid),
      .quo       (quo_l),
      .out_side  (dl_side)
   );

   ctp_div #(
      .NUM_W  (MAG_W),
      .DEN_W  (DW),
      .QUO_W  (MAG_W),
      .SIDE_W (1)
   ) u_div_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc2_ff),
      .num       (mag_r_c2_ff),
      .den       (den_mag_c2_ff),
      .in_side   (neg_r_c2_ff),
      .out_valid (dr_valid),
      .quo       (quo_r),
      .out_side  (dr_neg)
   );

   function automatic ctp_pkg::line_type sat_line(input logic neg, input logic [MAG_W-1:0] q);
      logic [MAG_W-1:0] pos_max;
      pos_max = MAG_W'({1'b0, {(LW-1){1'b1}}});
      if (neg) begin
         if (q > pos_max) begin
            sat_line = {1'b1, {(LW-1){1'b0}}};
         end else begin
            sat_line = LW'(-q);
         end
      end else begin
         if (q > pos_max) begin
            sat_line = {1'b0, {(LW-1){1'b1}}};
         end else begin
            sat_line = q[LW-1:0];
         end
      end
   endfunction

   logic                  vo_ff;
   ctp_pkg::line_res_type res_ff, res_in;
   logic [SIDE_W-1:0]     side_o_ff;

   always_comb begin
      res_in.vertical = dl_side[SIDE_W];
      res_in.left_y   = sat_line(dl_side[SIDE_W+1], quo_l);
      res_in.right_y  = sat_line(dr_neg, quo_r);
      if (dl_side[SIDE_W]) begin
         res_in.left_y  = '0;
         res_in.right_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff    <= res_in;
      side_o_ff <= dl_side[SIDE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= dl_valid & dr_valid;
      end
   end

   assign out_valid = vo_ff;
   assign result    = res_ff;
   assign out_side  = side_o_ff;

endmodule

// ----- hw/rtl/circle_tangent_from_point_unit.sv -----
// Tangent lines from a point to a circle.
// Input: pulse start with the circle (req_center_x/y, req_radius) and the
// point (req_point_x/y). busy stays low, so an item is taken every cycle
// that start is high.
// Output: rsp_strobe is high for one cycle with the result fields; the
// receiver cannot hold results off and none is needed.
// One item per cycle sustained. The pipeline depth is set by the
// bit-serial dividers for the tangent parameters (FRACTION_BITS + 5
// stages), the root extraction (FRACTION_BITS + 3) and the line-clip
// dividers (34 stages).
// Results come out in the order items went in.
// csr_write_enable/csr_write_data set window_width, used when an item
// reaches the line stages; write it only while no item is in flight.
// Reset: synchronous, clears every stage valid bit and sets
// window_width to 640; items in flight are dropped.
module circle_tangent_from_point_unit #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ctp_pkg::coord_type                req_center_x,
   input  ctp_pkg::coord_type                req_center_y,
   input  logic [ctp_pkg::RADIUS_W-1:0]      req_radius,
   input  ctp_pkg::coord_type                req_point_x,
   input  ctp_pkg::coord_type                req_point_y,
   input  logic                              csr_write_enable,
   input  logic [ctp_pkg::WIDTH_W-1:0]       csr_write_data,
   output logic                              rsp_strobe,
   output logic                              rsp_valid_res,
   output ctp_pkg::coord_type                rsp_first_tangent_x,
   output ctp_pkg::coord_type                rsp_first_tangent_y,
   output ctp_pkg::coord_type                rsp_second_tangent_x,
   output ctp_pkg::coord_type                rsp_second_tangent_y,
   output logic                              rsp_first_line_vertical,
   output ctp_pkg::line_type                 rsp_first_line_left_y,
   output ctp_pkg::line_type                 rsp_first_line_right_y,
   output logic                              rsp_second_line_vertical,
   output ctp_pkg::line_type                 rsp_second_line_left_y,
   output ctp_pkg::line_type                 rsp_second_line_right_y
);

   localparam int F   = FRACTION_BITS;
   localparam int CW  = ctp_pkg::COORD_W;
   localparam int DW  = ctp_pkg::DIFF_W;
   localparam int QW  = F + 5;
   localparam int TNW = 35 + F;
   localparam int TDW = 35;
   localparam int QNW = 30 + F;
   localparam int QDW = 32;
   localparam int TW  = QW + 1;
   localparam int XW  = 2 * F + 6;
   localparam int RW  = F + 3;
   localparam int UW  = RW + 1;
   localparam int PW  = F + 26;
   localparam int U2W = 2 * F + 13;
   localparam int GEO_W = 4 * CW + 2 * DW;
   localparam int TMW = TW + DW;
   localparam int UMW = UW + DW;

   assign busy = 1'b0;

   logic [ctp_pkg::WIDTH_W-1:0] width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ctp_pkg::WIDTH_RESET;
      end else if (csr_write_enable) begin
         width_ff <= csr_write_data;
      end
   end

   // s1: capture
   logic v1_ff;
   ctp_pkg::coord_type cx1_ff, cy1_ff, px1_ff, py1_ff;
   logic [ctp_pkg::RADIUS_W-1:0] r1_ff;

   always_ff @(posedge clock) begin
      cx1_ff <= req_center_x;
      cy1_ff <= req_center_y;
      r1_ff  <= req_radius;
      px1_ff <= req_point_x;
      py1_ff <= req_point_y;
   end

   // s2: differences and truncated midpoint offset
   logic v2_ff;
   ctp_pkg::diff_type dx2_ff, dy2_ff, ex2_ff, ey2_ff;
   ctp_pkg::diff_type ex2_in, ey2_in;
   ctp_pkg::coord_type cx2_ff, cy2_ff, px2_ff, py2_ff;
   logic [ctp_pkg::RADIUS_W-1:0] r2_ff;

   always_comb begin
      ctp_pkg::diff_type sx, sy, hx, hy;
      sx = DW'(cx1_ff) + DW'(px1_ff);
      sy = DW'(cy1_ff) + DW'(py1_ff);
      hx = (sx + (sx[DW-1] ? DW'(1) : DW'(0))) >>> 1;
      hy = (sy + (sy[DW-1] ? DW'(1) : DW'(0))) >>> 1;
      ex2_in = hx - DW'(cx1_ff);
      ey2_in = hy - DW'(cy1_ff);
   end

   always_ff @(posedge clock) begin
      dx2_ff <= DW'(px1_ff) - DW'(cx1_ff);
      dy2_ff <= DW'(py1_ff) - DW'(cy1_ff);
      ex2_ff <= ex2_in;
      ey2_ff <= ey2_in;
      cx2_ff <= cx1_ff;
      cy2_ff <= cy1_ff;
      px2_ff <= px1_ff;
      py2_ff <= py1_ff;
      r2_ff  <= r1_ff;
   end

   // s3: squares
   logic v3_ff;
   logic [31:0] dxsq3_ff, dysq3_ff;
   logic [30:0] exsq3_ff, eysq3_ff;
   logic [29:0] rsq3_ff;
   logic signed [2*DW-1:0] dxsq_in, dysq_in, exsq_in, eysq_in;
   logic [GEO_W-1:0] geo3_ff;

   assign dxsq_in = (2*DW)'(dx2_ff) * (2*DW)'(dx2_ff);
   assign dysq_in = (2*DW)'(dy2_ff) * (2*DW)'(dy2_ff);
   assign exsq_in = (2*DW)'(ex2_ff) * (2*DW)'(ex2_ff);
   assign eysq_in = (2*DW)'(ey2_ff) * (2*DW)'(ey2_ff);

   always_ff @(posedge clock) begin
      dxsq3_ff <= dxsq_in[31:0];
      dysq3_ff <= dysq_in[31:0];
      exsq3_ff <= exsq_in[30:0];
      eysq3_ff <= eysq_in[30:0];
      rsq3_ff  <= 30'(r2_ff) * 30'(r2_ff);
      geo3_ff  <= {cx2_ff, cy2_ff, px2_ff, py2_ff, ex2_ff, ey2_ff};
   end

   // s4: sums
   logic v4_ff;
   logic [32:0] s4_ff;
   logic [31:0] d24_ff;
   logic [29:0] rsq4_ff;
   logic        out4_ff;
   logic [32:0] s4_in;
   logic [GEO_W-1:0] geo4_ff;

   assign s4_in = 33'(dxsq3_ff) + 33'(dysq3_ff);

   always_ff @(posedge clock) begin
      s4_ff   <= s4_in;
      d24_ff  <= 32'(exsq3_ff) + 32'(eysq3_ff);
      rsq4_ff <= rsq3_ff;
      out4_ff <= (s4_in > 33'(rsq3_ff));
      geo4_ff <= geo3_ff;
   end

   // s5: numerator of t
   logic v5_ff;
   logic [34:0] mag5_ff;
   logic        mneg5_ff, zero5_ff, out5_ff;
   logic [31:0] d25_ff;
   logic [29:0] rsq5_ff;
   logic [GEO_W-1:0] geo5_ff;
   logic signed [35:0] m_in;

   assign m_in = $signed({4'b0, rsq4_ff, 2'b0}) - $signed({3'b0, s4_ff})
                 + $signed({2'b0, d24_ff, 2'b0});

   always_ff @(posedge clock) begin
      mag5_ff  <= m_in[35] ? 35'(-m_in) : 35'(m_in);
      mneg5_ff <= m_in[35];
      zero5_ff <= (d24_ff == '0);
      out5_ff  <= out4_ff;
      d25_ff   <= d24_ff;
      rsq5_ff  <= rsq4_ff;
      geo5_ff  <= geo4_ff;
   end

   // t = M / (8 D2) and q = r^2 / D2, both with F fraction bits
   logic          tdiv_valid, qdiv_valid;
   logic [QW-1:0] tq, qq;
   logic [GEO_W+1:0] tdiv_side;
   logic          qdiv_zero;

   ctp_div #(
      .NUM_W  (TNW),
      .DEN_W  (TDW),
      .QUO_W  (QW),
      .SIDE_W (GEO_W + 2)
   ) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .num       ({mag5_ff, {F{1'b0}}}),
      .den       ({d25_ff, 3'b000}),
      .in_side   ({out5_ff, mneg5_ff, geo5_ff}),
      .out_valid (tdiv_valid),
      .quo       (tq),
      .out_side  (tdiv_side)
   );

   ctp_div #(
      .NUM_W  (QNW),
      .DEN_W  (QDW),
      .QUO_W  (QW),
      .SIDE_W (1)
   ) u_div_q (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .num       ({rsq5_ff, {F{1'b0}}}),
      .den       (d25_ff),
      .in_side   (zero5_ff),
      .out_valid (qdiv_valid),
      .quo       (qq),
      .out_side  (qdiv_zero)
   );

   // s6: signed t
   logic v6_ff;
   logic signed [TW-1:0] tf6_ff, tq_s;
   logic [QW-1:0] q6_ff;
   logic zero6_ff, out6_ff;
   logic [GEO_W-1:0] geo6_ff;

   assign tq_s = $signed({1'b0, tq});

   always_ff @(posedge clock) begin
      tf6_ff   <= tdiv_side[GEO_W] ? -tq_s : tq_s;
      q6_ff    <= qq;
      zero6_ff <= qdiv_zero;
      out6_ff  <= tdiv_side[GEO_W+1];
      geo6_ff  <= tdiv_side[GEO_W-1:0];
   end

   // s7: t squared
   logic v7_ff;
   logic signed [2*TW-1:0] tsq7_ff;
   logic signed [TW-1:0] tf7_ff;
   logic [QW-1:0] q7_ff;
   logic zero7_ff, out7_ff;
   logic [GEO_W-1:0] geo7_ff;

   always_ff @(posedge clock) begin
      tsq7_ff  <= (2*TW)'(tf6_ff) * (2*TW)'(tf6_ff);
      tf7_ff   <= tf6_ff;
      q7_ff    <= q6_ff;
      zero7_ff <= zero6_ff;
      out7_ff  <= out6_ff;
      geo7_ff  <= geo6_ff;
   end

   // s8: u^2 = q - t^2, clamped at zero
   logic v8_ff;
   logic [XW-1:0] rad8_ff;
   logic signed [TW-1:0] tf8_ff;
   logic zero8_ff, out8_ff;
   logic [GEO_W-1:0] geo8_ff;
   logic signed [U2W-1:0] u2_in;

   assign u2_in = $signed({{(U2W-QW-F){1'b0}}, q7_ff, {F{1'b0}}}) - U2W'(tsq7_ff);

   always_ff @(posedge clock) begin
      rad8_ff  <= (u2_in > 0) ? u2_in[XW-1:0] : '0;
      tf8_ff   <= tf7_ff;
      zero8_ff <= zero7_ff;
      out8_ff  <= out7_ff;
      geo8_ff  <= geo7_ff;
   end

   localparam int SQ_SIDE_W = GEO_W + TW + 2;

   logic          sq_valid;
   logic [RW-1:0] uf;
   logic [SQ_SIDE_W-1:0] sq_side;

   ctp_sqrt #(
      .RAD_W  (XW),
      .SIDE_W (SQ_SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v8_ff),
      .radicand  (rad8_ff),
      .in_side   ({out8_ff, zero8_ff, tf8_ff, geo8_ff}),
      .out_valid (sq_valid),
      .root      (uf),
      .out_side  (sq_side)
   );

   ctp_pkg::coord_type sq_cx, sq_cy, sq_px, sq_py;
   ctp_pkg::diff_type  sq_ex, sq_ey;
   logic signed [TW-1:0] sq_tf;
   logic signed [UW-1:0] uf_s;

   assign {sq_cx, sq_cy, sq_px, sq_py, sq_ex, sq_ey} = sq_side[GEO_W-1:0];
   assign sq_tf = sq_side[GEO_W+TW-1:GEO_W];
   assign uf_s  = $signed({1'b0, uf});

   // s9: products with the midpoint offset
   logic v9_ff;
   logic signed [TMW-1:0] tex9_ff, tey9_ff;
   logic signed [UMW-1:0] uex9_ff, uey9_ff;
   ctp_pkg::coord_type cx9_ff, cy9_ff, px9_ff, py9_ff;
   logic zero9_ff, out9_ff;

   always_ff @(posedge clock) begin
      tex9_ff  <= TMW'(sq_tf) * TMW'(sq_ex);
      tey9_ff  <= TMW'(sq_tf) * TMW'(sq_ey);
      uex9_ff  <= UMW'(uf_s) * UMW'(sq_ex);
      uey9_ff  <= UMW'(uf_s) * UMW'(sq_ey);
      cx9_ff   <= sq_cx;
      cy9_ff   <= sq_cy;
      px9_ff   <= sq_px;
      py9_ff   <= sq_py;
      zero9_ff <= sq_side[GEO_W+TW];
      out9_ff  <= sq_side[GEO_W+TW+1];
   end

   // s10: base point
   logic v10_ff;
   logic signed [PW-1:0] bx10_ff, by10_ff;
   logic signed [UMW-1:0] uex10_ff, uey10_ff;
   ctp_pkg::coord_type cx10_ff, cy10_ff, px10_ff, py10_ff;
   logic zero10_ff, out10_ff;

   always_ff @(posedge clock) begin
      bx10_ff   <= (PW'(cx9_ff) <<< F) + PW'(tex9_ff);
      by10_ff   <= (PW'(cy9_ff) <<< F) + PW'(tey9_ff);
      uex10_ff  <= uex9_ff;
      uey10_ff  <= uey9_ff;
      cx10_ff   <= cx9_ff;
      cy10_ff   <= cy9_ff;
      px10_ff   <= px9_ff;
      py10_ff   <= py9_ff;
      zero10_ff <= zero9_ff;
      out10_ff  <= out9_ff;
   end

   // s11: tangent points in fixed point
   logic v11_ff;
   logic signed [PW-1:0] p1x11_ff, p1y11_ff, p2x11_ff, p2y11_ff;
   ctp_pkg::coord_type cx11_ff, cy11_ff, px11_ff, py11_ff;
   logic zero11_ff, out11_ff;

   always_ff @(posedge clock) begin
      p1x11_ff  <= bx10_ff + PW'(uey10_ff);
      p1y11_ff  <= by10_ff - PW'(uex10_ff);
      p2x11_ff  <= bx10_ff - PW'(uey10_ff);
      p2y11_ff  <= by10_ff + PW'(uex10_ff);
      cx11_ff   <= cx10_ff;
      cy11_ff   <= cy10_ff;
      px11_ff   <= px10_ff;
      py11_ff   <= py10_ff;
      zero11_ff <= zero10_ff;
      out11_ff  <= out10_ff;
   end

   function automatic ctp_pkg::coord_type fix_to_coord(input logic signed [PW-1:0] v);
      logic [PW-1:0]   mag;
      logic [PW-F-1:0] ip;
      mag = v[PW-1] ? PW'(-v) : PW'(v);
      ip  = mag[PW-1:F];
      if (v[PW-1]) begin
         if (ip > (PW-F)'(ctp_pkg::COORD_MIN_MAG)) begin
            fix_to_coord = {1'b1, {(CW-1){1'b0}}};
         end else begin
            fix_to_coord = CW'(-ip);
         end
      end else begin
         if (ip > (PW-F)'(ctp_pkg::COORD_MAX)) begin
            fix_to_coord = {1'b0, {(CW-1){1'b1}}};
         end else begin
            fix_to_coord = ip[CW-1:0];
         end
      end
   endfunction

   // s12: truncate and saturate to integer pixels
   logic v12_ff;
   ctp_pkg::coord_type t1x12_ff, t1y12_ff, t2x12_ff, t2y12_ff;
   ctp_pkg::coord_type px12_ff, py12_ff;
   logic out12_ff;

   always_ff @(posedge clock) begin
      if (zero11_ff) begin
         t1x12_ff <= cx11_ff;
         t1y12_ff <= cy11_ff;
         t2x12_ff <= cx11_ff;
         t2y12_ff <= cy11_ff;
      end else begin
         t1x12_ff <= fix_to_coord(p1x11_ff);
         t1y12_ff <= fix_to_coord(p1y11_ff);
         t2x12_ff <= fix_to_coord(p2x11_ff);
         t2y12_ff <= fix_to_coord(p2y11_ff);
      end
      px12_ff  <= px11_ff;
      py12_ff  <= py11_ff;
      out12_ff <= out11_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
      end else begin
         v1_ff  <= start & ~busy;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= tdiv_valid;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= sq_valid;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
      end
   end

   // line clipping at x = -width and x = 2*width
   ctp_pkg::diff_type clip_left, clip_right;

   assign clip_left  = -$signed({{(DW-ctp_pkg::WIDTH_W){1'b0}}, width_ff});
   assign clip_right = $signed({{(DW-ctp_pkg::WIDTH_W-1){1'b0}}, width_ff, 1'b0});

   logic                  l1_valid, l2_valid;
   ctp_pkg::line_res_type l1_res, l2_res;
   logic [4*CW-1:0]       l1_side;
   logic                  l2_out;

   ctp_line #(
      .SIDE_W (4 * CW)
   ) u_line_first (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v12_ff),
      .point_x    (px12_ff),
      .point_y    (py12_ff),
      .tan_x      (t1x12_ff),
      .tan_y      (t1y12_ff),
      .clip_left  (clip_left),
      .clip_right (clip_right),
      .in_side    ({t1x12_ff, t1y12_ff, t2x12_ff, t2y12_ff}),
      .out_valid  (l1_valid),
      .result     (l1_res),
      .out_side   (l1_side)
   );

   ctp_line #(
      .SIDE_W (1)
   ) u_line_second (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v12_ff),
      .point_x    (px12_ff),
      .point_y    (py12_ff),
      .tan_x      (t2x12_ff),
      .tan_y      (t2y12_ff),
      .clip_left  (clip_left),
      .clip_right (clip_right),
      .in_side    (out12_ff),
      .out_valid  (l2_valid),
      .result     (l2_res),
      .out_side   (l2_out)
   );

   // output register; a point on or inside the circle clears every field
   logic                  strobe_ff;
   logic                  vres_ff;
   ctp_pkg::coord_type    t1x_ff, t1y_ff, t2x_ff, t2y_ff;
   ctp_pkg::line_res_type l1_ff, l2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= l1_valid;
      end
   end

   always_ff @(posedge clock) begin
      vres_ff <= l2_out;
      if (l2_out) begin
         {t1x_ff, t1y_ff, t2x_ff, t2y_ff} <= l1_side;
         l1_ff <= l1_res;
         l2_ff <= l2_res;
      end else begin
         {t1x_ff, t1y_ff, t2x_ff, t2y_ff} <= '0;
         l1_ff <= '0;
         l2_ff <= '0;
      end
   end

   assign rsp_strobe               = strobe_ff;
   assign rsp_valid_res            = vres_ff;
   assign rsp_first_tangent_x      = t1x_ff;
   assign rsp_first_tangent_y      = t1y_ff;
   assign rsp_second_tangent_x     = t2x_ff;
   assign rsp_second_tangent_y     = t2y_ff;
   assign rsp_first_line_vertical  = l1_ff.vertical;
   assign rsp_first_line_left_y    = l1_ff.left_y;
   assign rsp_first_line_right_y   = l1_ff.right_y;
   assign rsp_second_line_vertical = l2_ff.vertical;
   assign rsp_second_line_left_y   = l2_ff.left_y;
   assign rsp_second_line_right_y  = l2_ff.right_y;

`ifndef SYNTHESIS
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      tdiv_valid == qdiv_valid)
      else $error("t and q dividers out of step");

   a_line_lockstep: assert property (@(posedge clock) disable iff (reset)
      l1_valid == l2_valid)
      else $error("line units out of step");

   a_invalid_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |-> (rsp_first_tangent_x == '0 &&
      rsp_second_tangent_y == '0 && !rsp_first_line_vertical &&
      rsp_second_line_right_y == '0))
      else $error("result not cleared for point inside circle");

   a_vertical_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_first_line_vertical) |->
      (rsp_first_line_left_y == '0 && rsp_first_line_right_y == '0))
      else $error("vertical line with nonzero clip values");
`endif

endmodule
